@@ rtl/core/sfr_pkg.sv @@
// Shared types and constants for the sync frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

    // Sync pattern bytes
    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    // Field widths fixed by the interface
    localparam int BYTE_W = 8;
    localparam int LEN_CFG_W = 11;
    localparam int INDEX_W = 10;

    // Reset value of the body length register
    localparam logic [LEN_CFG_W-1:0] BODY_LENGTH_RESET = 11'd96;

    // Result event codes
    typedef enum logic [1:0] {
        EV_BODY  = 2'd0,
        EV_GOOD  = 2'd1,
        EV_CKERR = 2'd2
    } event_t;

    // One parser result, valid marks that a result is produced
    typedef struct packed {
        logic               valid;
        event_t             ev;
        logic [BYTE_W-1:0]  data;
        logic [INDEX_W-1:0] index;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/core/sync_frame_receiver_fletcher.sv @@
// Top level of the sync frame receiver with Fletcher-8 checksum.
//
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) takes one received byte per
//   transfer. The block hunts for the sync pair 0xB5 0x62, then passes each
//   of body_length body bytes out as a body event with its index, then checks
//   the two Fletcher-8 checksum bytes and reports frame good or checksum error.
//   Output channel (out_valid/out_ready) carries event_res, data_byte and
//   byte_index; sync and first-checksum-match bytes produce no result.
//   Configuration: cfg_wr_en/cfg_wr_data write body_length (saturated to
//   1 .. MAX_BODY_BYTES); write only while the block is idle.
//   Path: each byte is registered in the input register, and its parser result
//   then loads the output register once the output slot is free.
//   Throughput: one byte per cycle while the output is not stalled; the parser
//   step updates position and both checksum sums.
//   Reset: rst_n clears the hunt state, sums and valid flags, and sets
//   body_length to 96.
//   Stall: when out_ready is low the output holds; one byte more is taken
//   into the input register, after which in_ready drops until the output
//   drains.
`timescale 1ns / 1ps
`default_nettype none

module sync_frame_receiver_fletcher
    import sfr_pkg::*;
#(
    parameter int MAX_BODY_BYTES = 1024
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [LEN_CFG_W-1:0] cfg_wr_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [BYTE_W-1:0]    rx_byte,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [1:0]                event_res,
    output logic [BYTE_W-1:0]         data_byte,
    output logic [INDEX_W-1:0]        byte_index
);

    // Largest length the 11-bit register can reach within the limit
    localparam int CFG_MAX = (1 << LEN_CFG_W) - 1;
    localparam int EFF_MAX = (MAX_BODY_BYTES < CFG_MAX) ? MAX_BODY_BYTES : CFG_MAX;
    localparam int POS_W   = $clog2(EFF_MAX + 4);

    logic [LEN_CFG_W-1:0] body_length_reg;
    logic [POS_W-1:0]     eff_len;

    logic                 in_valid_reg;
    logic [BYTE_W-1:0]    in_byte_reg;

    logic                 out_free;
    logic                 advance;
    result_t              result;

    // Body length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_length_reg <= BODY_LENGTH_RESET;
        end
        else if (cfg_wr_en)
        begin
            body_length_reg <= cfg_wr_data;
        end
    end

    // Saturate length to 1 .. MAX_BODY_BYTES
    always_comb
    begin
        if (body_length_reg == '0)
        begin
            eff_len = POS_W'(1);
        end
        else if (32'(body_length_reg) > EFF_MAX)
        begin
            eff_len = POS_W'(EFF_MAX);
        end
        else
        begin
            eff_len = POS_W'(body_length_reg);
        end
    end

    // Input register stage
    assign advance  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    sfr_parser #(
        .POS_W (POS_W)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_data (in_byte_reg),
        .eff_len (eff_len),
        .result  (result)
    );

    sfr_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .result     (result),
        .free       (out_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_res  (event_res),
        .data_byte  (data_byte),
        .byte_index (byte_index)
    );

`ifndef SYNTH
    // Input backpressure only when the input stage is full behind a stalled output
    a_ready_low_only_when_stalled: assert property (
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_valid_reg && out_valid && !out_ready)
    ) else $error("in_ready low without a stalled output");

    // Frame events carry zero data and index
    a_frame_event_zero_payload: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && (event_res != EV_BODY)) |-> (data_byte == '0 && byte_index == '0)
    ) else $error("frame event with nonzero payload");

    // A byte processed with the output free leaves the result in the output slot
    a_result_lands: assert property (
        @(posedge clk) disable iff (!rst_n)
        (advance && result.valid) |=> out_valid
    ) else $error("parser result lost");
`endif

endmodule

`default_nettype wire

@@ rtl/core/sfr_parser.sv @@
// Frame parser: position counter, Fletcher checksum and per-byte result logic.
`timescale 1ns / 1ps
`default_nettype none

module sfr_parser
    import sfr_pkg::*;
#(
    parameter int POS_W = 11
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [BYTE_W-1:0] rx_data,
    input  wire logic [POS_W-1:0]  eff_len,
    output result_t                result
);

    logic [POS_W-1:0]  position_reg;
    logic [POS_W-1:0]  position_next;
    logic [BYTE_W-1:0] sum_a_reg;
    logic [BYTE_W-1:0] sum_a_next;
    logic [BYTE_W-1:0] sum_b_reg;
    logic [BYTE_W-1:0] sum_b_next;

    logic [POS_W-1:0]  body_pos;
    logic [BYTE_W-1:0] sum_a_add;
    logic              in_body;

    localparam logic [POS_W-1:0] POS_HUNT1 = POS_W'(0);
    localparam logic [POS_W-1:0] POS_HUNT2 = POS_W'(1);
    localparam logic [POS_W-1:0] POS_BODY  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_CK2   = POS_W'(3);

    assign body_pos  = position_reg - POS_BODY;
    assign in_body   = (position_reg >= POS_BODY) && (body_pos < eff_len);
    assign sum_a_add = sum_a_reg + rx_data;

    // Next state and result for the byte in flight
    always_comb
    begin
        position_next = position_reg;
        sum_a_next    = sum_a_reg;
        sum_b_next    = sum_b_reg;
        result        = '{valid: 1'b0, ev: EV_BODY, data: '0, index: '0};
        if (position_reg == POS_HUNT1)
        begin
            position_next = (rx_data == SYNC_FIRST) ? POS_HUNT2 : POS_HUNT1;
        end
        else if (position_reg == POS_HUNT2)
        begin
            if (rx_data == SYNC_SECOND)
            begin
                position_next = POS_BODY;
                sum_a_next    = '0;
                sum_b_next    = '0;
            end
            else
            begin
                position_next = POS_HUNT1;
            end
        end
        else if (in_body)
        begin
            sum_a_next    = sum_a_add;
            sum_b_next    = sum_b_reg + sum_a_add;
            position_next = position_reg + POS_W'(1);
            result.valid  = 1'b1;
            result.ev     = EV_BODY;
            result.data   = rx_data;
            result.index  = INDEX_W'(body_pos);
        end
        else if (position_reg == eff_len + POS_BODY)
        begin
            if (rx_data == sum_a_reg)
            begin
                position_next = position_reg + POS_W'(1);
            end
            else
            begin
                position_next = POS_HUNT1;
                result.valid  = 1'b1;
                result.ev     = EV_CKERR;
            end
        end
        else if (position_reg == eff_len + POS_CK2)
        begin
            position_next = POS_HUNT1;
            result.valid  = 1'b1;
            result.ev     = (rx_data == sum_b_reg) ? EV_GOOD : EV_CKERR;
        end
        else
        begin
            // Length shrank mid-frame: drop the byte and hunt again
            position_next = POS_HUNT1;
        end
    end

    // State registers, updated once per processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            sum_a_reg    <= '0;
            sum_b_reg    <= '0;
        end
        else if (step)
        begin
            position_reg <= position_next;
            sum_a_reg    <= sum_a_next;
            sum_b_reg    <= sum_b_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/sfr_out_stage.sv @@
// Output register holding one result until the downstream transfer.
`timescale 1ns / 1ps
`default_nettype none

module sfr_out_stage
    import sfr_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  result_t                  result,
    output logic                     free,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [1:0]               event_res,
    output logic [BYTE_W-1:0]        data_byte,
    output logic [INDEX_W-1:0]       byte_index
);

    logic               valid_reg;
    event_t             ev_reg;
    logic [BYTE_W-1:0]  data_reg;
    logic [INDEX_W-1:0] index_reg;

    // Slot can take a new result when empty or draining this cycle
    assign free = !valid_reg || out_ready;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= result.valid;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (load && result.valid)
        begin
            ev_reg    <= result.ev;
            data_reg  <= result.data;
            index_reg <= result.index;
        end
    end

    assign out_valid  = valid_reg;
    assign event_res  = ev_reg;
    assign data_byte  = data_reg;
    assign byte_index = index_reg;

endmodule

`default_nettype wire

@@ dv/tb_sync_frame_receiver_fletcher.sv @@
// Testbench for the sync frame receiver: directed and random byte streams checked against a predictor.
`timescale 1ns / 1ps

module tb_sync_frame_receiver_fletcher;
    import sfr_pkg::*;

    localparam int MAX_BODY_BYTES = 1024;
    localparam int DRAIN_CYCLES = 6;      // margin after the last expected result has arrived
    localparam int WATCHDOG_LIMIT = 4000; // cycles without any transfer
    localparam int HOLD_CYCLES = 300;     // long receiver hold-off for the pressure test

    // One expected or observed result
    typedef struct packed {
        event_t             ev;
        logic [BYTE_W-1:0]  data;
        logic [INDEX_W-1:0] idx;
    } frame_event_t;

    // Kinds of byte sequences the stimulus builds
    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_CK_A,
        FRAME_BAD_CK_B,
        FRAME_BAD_SYNC,
        FRAME_SHORT,
        FRAME_NOISE
    } frame_kind_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [LEN_CFG_W-1:0] cfg_wr_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [BYTE_W-1:0]    rx_byte;
    logic                 out_valid;
    logic                 out_ready;
    logic [1:0]           event_res;
    logic [BYTE_W-1:0]    data_byte;
    logic [INDEX_W-1:0]   byte_index;

    // Predictor state: configured length, frame position and running sums
    logic [LEN_CFG_W-1:0] body_len_cfg = BODY_LENGTH_RESET;
    int                   frame_pos = 0;
    logic [7:0]           ck_a = 8'd0;
    logic [7:0]           ck_b = 8'd0;

    frame_event_t expected_events[$];

    int error_count = 0;
    int items_sent = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int rx_hold_req = 0;

    sync_frame_receiver_fletcher #(
        .MAX_BODY_BYTES(MAX_BODY_BYTES)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_res  (event_res),
        .data_byte  (data_byte),
        .byte_index (byte_index)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Body length after saturation to 1 .. MAX_BODY_BYTES
    function automatic int effective_length();
        int len;
        len = int'(body_len_cfg);
        if (len < 1)
            len = 1;
        if (len > MAX_BODY_BYTES)
            len = MAX_BODY_BYTES;
        return len;
    endfunction

    // Advance the parser prediction by one accepted byte
    task automatic predict_frame_byte(input logic [7:0] b);
        int           len;
        frame_event_t e;
        len = effective_length();
        e = '0;
        if (frame_pos == 0)
        begin
            frame_pos = (b == SYNC_FIRST) ? 1 : 0;
        end
        else if (frame_pos == 1)
        begin
            if (b == SYNC_SECOND)
            begin
                frame_pos = 2;
                ck_a = 8'd0;
                ck_b = 8'd0;
            end
            else
                frame_pos = 0;
        end
        else if (frame_pos - 2 < len)
        begin
            ck_a = ck_a + b;
            ck_b = ck_b + ck_a;
            e.ev = EV_BODY;
            e.data = b;
            e.idx = INDEX_W'(frame_pos - 2);
            expected_events.push_back(e);
            frame_pos++;
        end
        else if (frame_pos == len + 2)
        begin
            if (b == ck_a)
                frame_pos++;
            else
            begin
                frame_pos = 0;
                e.ev = EV_CKERR;
                expected_events.push_back(e);
            end
        end
        else if (frame_pos == len + 3)
        begin
            frame_pos = 0;
            e.ev = (b == ck_b) ? EV_GOOD : EV_CKERR;
            expected_events.push_back(e);
        end
        else
        begin
            // length shrank under an open frame: byte dropped
            frame_pos = 0;
        end
    endtask

    // Byte with extra weight on the sync values
    function automatic logic [7:0] rand_byte();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return SYNC_FIRST;
        if (roll < 15)
            return SYNC_SECOND;
        return 8'($urandom_range(255));
    endfunction

    // Offer one byte, with random idle cycles first, and wait for the transfer
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_frame_byte(b);
        items_sent++;
    endtask

    // Stop offering and wait until every expected result has arrived
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the body length register; only called with the block idle
    task automatic write_length(input logic [LEN_CFG_W-1:0] len);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        body_len_cfg = len;
    endtask

    task automatic send_bytes(input logic [7:0] seq[]);
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    // Build one sequence of the given kind at the current length
    task automatic send_frame(input frame_kind_t kind);
        int         n;
        int         cut;
        logic [7:0] v;
        logic [7:0] tx_a;
        logic [7:0] tx_b;
        n = effective_length();
        tx_a = 8'd0;
        tx_b = 8'd0;
        case (kind)
            FRAME_NOISE:
                repeat ($urandom_range(6, 1)) send_byte(rand_byte());
            FRAME_BAD_SYNC:
            begin
                send_byte(SYNC_FIRST);
                send_byte($urandom_range(1) ? SYNC_FIRST : rand_byte());
            end
            FRAME_SHORT:
            begin
                send_byte(SYNC_FIRST);
                send_byte(SYNC_SECOND);
                cut = $urandom_range(n - 1, 0);
                repeat (cut) send_byte(rand_byte());
            end
            default:
            begin
                send_byte(SYNC_FIRST);
                send_byte(SYNC_SECOND);
                for (int i = 0; i < n; i++)
                begin
                    v = rand_byte();
                    tx_a = tx_a + v;
                    tx_b = tx_b + tx_a;
                    send_byte(v);
                end
                if (kind == FRAME_BAD_CK_A)
                    tx_a = tx_a ^ 8'($urandom_range(255, 1));
                send_byte(tx_a);
                // after a bad first checksum byte the block is already hunting
                if (kind != FRAME_BAD_CK_A)
                begin
                    if (kind == FRAME_BAD_CK_B)
                        tx_b = tx_b ^ 8'($urandom_range(255, 1));
                    send_byte(tx_b);
                end
            end
        endcase
    endtask

    // ---------------- tests ----------------

    // Reset length of 96: a few body bytes with their indexes
    task automatic test_default_length();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_bytes('{8'hB5, 8'h62, 8'h11, 8'h22, 8'h33});
        wait_drain();
    endtask

    // Shrink length under the open frame: next byte is dropped, even a sync byte
    task automatic test_length_shrink();
        write_length(11'd1);
        send_bytes('{8'hB5, 8'h62});
        wait_drain();
    endtask

    // Wrong first checksum byte ends the frame at once; wrong second one too
    task automatic test_checksum_errors();
        send_bytes('{8'hB5, 8'h62, 8'h10, 8'h11});
        send_bytes('{8'hB5, 8'h62, 8'h10, 8'h10, 8'h11});
        wait_drain();
    endtask

    // A repeated first sync byte returns to the hunt; a good frame follows
    task automatic test_sync_mismatch();
        send_bytes('{8'hB5, 8'hB5, 8'h62, 8'h00});
        send_bytes('{8'hB5, 8'h62, 8'h00, 8'h00, 8'h00});
        wait_drain();
    endtask

    // Length zero saturates to one
    task automatic test_length_saturation_low();
        write_length(11'd0);
        send_bytes('{8'hB5, 8'h62, 8'hFF, 8'hFF, 8'hFF});
        wait_drain();
    endtask

    // Length 2047 saturates to the full 1024-byte body
    task automatic test_long_frame();
        write_length(11'h7FF);
        send_idle_pct = 22;
        recv_stall_pct = 22;
        send_frame(FRAME_GOOD);
        wait_drain();
    endtask

    // Receiver holds off while the sender keeps offering body bytes
    task automatic test_backpressure();
        write_length(11'd1024);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rx_hold_req = HOLD_CYCLES;
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        repeat (40) send_byte(rand_byte());
        wait_drain();
    endtask

    // Random mix of frames at one length and one idling setting
    task automatic run_phase(input logic [LEN_CFG_W-1:0] len, input int s_idle,
                             input int r_stall, input int n_items);
        int start;
        int roll;
        write_length(len);
        send_idle_pct = s_idle;
        recv_stall_pct = r_stall;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            roll = $urandom_range(99);
            if (roll < 70)
                send_frame(FRAME_GOOD);
            else if (roll < 78)
                send_frame(FRAME_BAD_CK_A);
            else if (roll < 86)
                send_frame(FRAME_BAD_CK_B);
            else if (roll < 92)
                send_frame(FRAME_BAD_SYNC);
            else if (roll < 96)
                send_frame(FRAME_SHORT);
            else
                send_frame(FRAME_NOISE);
        end
        wait_drain();
    endtask

    task automatic test_random_phases();
        run_phase(11'd3, 0, 0, 200);
        run_phase(11'd1, 87, 0, 200);
        run_phase(11'd8, 0, 87, 200);
        run_phase(11'd0, 22, 22, 100);
        run_phase(11'd13, 0, 0, 100);
    endtask

    // ---------------- main sequence ----------------
    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        rx_byte <= '0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_length();
        test_length_shrink();
        test_checksum_errors();
        test_sync_mismatch();
        test_length_saturation_low();
        test_long_frame();
        test_backpressure();
        test_random_phases();

        wait_drain();
        if (expected_events.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_events.size());
            error_count++;
        end
        if (error_count == 0)
            $display("tb_sync_frame_receiver_fletcher: done, clean");
        else
            $display("tb_sync_frame_receiver_fletcher: done, errors");
        $finish;
    end

    // Receiver: random stalls, long hold-off on request, result check per transfer
    initial
    begin
        frame_event_t exp_ev;
        int           hold_left;
        hold_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (expected_events.size() == 0)
                begin
                    $error("unexpected result: event_res %0d data_byte %0d byte_index %0d",
                           event_res, data_byte, byte_index);
                    error_count++;
                end
                else
                begin
                    exp_ev = expected_events.pop_front();
                    if (event_res !== exp_ev.ev)
                    begin
                        $error("event_res: expected %0d, actual %0d", exp_ev.ev, event_res);
                        error_count++;
                    end
                    if (data_byte !== exp_ev.data)
                    begin
                        $error("data_byte: expected %0d, actual %0d", exp_ev.data, data_byte);
                        error_count++;
                    end
                    if (byte_index !== exp_ev.idx)
                    begin
                        $error("byte_index: expected %0d, actual %0d", exp_ev.idx, byte_index);
                        error_count++;
                    end
                end
            end
            if (rx_hold_req > 0)
            begin
                hold_left = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: too long without any transfer on either channel
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $error("no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_sync_frame_receiver_fletcher: done, errors");
        $finish;
    end

endmodule
